>>> src/imu_shq_pkg.sv
// Shared types, constants and helpers for the IMU sample health qualifier.
// No dependencies; every other file imports this package.

package imu_shq_pkg;

    localparam int unsigned NUM_CHECKED = 11;
    localparam logic [3:0] IDX_LAST = 4'(NUM_CHECKED - 1);

    localparam logic [19:0] HOLDOFF_RST  = 20'd10000;
    localparam logic [7:0]  RECOVERY_RST = 8'd20;

    localparam logic signed [15:0] SAMPLE_MIN = -16'sd32768;
    localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;

    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        ST_HELD  = 2'd0,
        ST_DUP   = 2'd1,
        ST_RECOV = 2'd2,
        ST_VALID = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXP_LO   = 2'd0,
        CFG_EXP_HI   = 2'd1,
        CFG_HOLDOFF  = 2'd2,
        CFG_RECOVERY = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [63:0]        now_us;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] temperature_raw;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic [7:0]         check_readback;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic signed [15:0] out_accel_x;
        logic signed [15:0] out_accel_y;
        logic signed [15:0] out_accel_z;
        logic signed [15:0] out_gyro_x;
        logic signed [15:0] out_gyro_y;
        logic signed [15:0] out_gyro_z;
        logic signed [15:0] out_temperature;
        logic               reset_request;
        logic [3:0]         next_check_index;
        logic [31:0]        mismatch_total;
    } t_out_word;

    typedef struct packed {
        logic [63:0] exp_lo;
        logic [23:0] exp_hi;
        logic [19:0] holdoff_us;
        logic [7:0]  recovery_ticks;
    } t_cfg;

    typedef struct packed {
        logic [63:0] deadline;
        logic [7:0]  recovery_left;
        logic [3:0]  check_idx;
        logic [47:0] last_triple;
        logic        dup_seen;
        logic [31:0] err_cnt;
    } t_state;

    function automatic logic [7:0] expected_byte(
        input logic [63:0] lo,
        input logic [23:0] hi,
        input logic [3:0]  idx
    );
        logic [7:0] b;
        b = '0;
        if (!idx[3]) begin
            b = lo[{idx[2:0], 3'b000} +: 8];
        end else if (idx[2:0] < 3'd3) begin
            b = hi[{idx[1:0], 3'b000} +: 8];
        end
        return b;
    endfunction

    function automatic logic signed [15:0] sat_negate(input logic signed [15:0] v);
        return (v == SAMPLE_MIN) ? SAMPLE_MAX : -v;
    endfunction

endpackage

>>> src/imu_shq_ifs.sv
// Valid/ready channel interfaces for poll words and result words.
// Depends on imu_shq_pkg for the payload types.

interface imu_shq_in_if import imu_shq_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface imu_shq_out_if import imu_shq_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/imu_shq_step.sv
// Combinational poll evaluation: next state and result word for one poll.
// Depends on imu_shq_pkg.

module imu_shq_step import imu_shq_pkg::*; (
    input  t_in_word  i_in,
    input  t_state    i_state,
    input  t_cfg      i_cfg,
    output t_state    o_state,
    output t_out_word o_word
);

    logic        held;
    logic        checking;
    logic        mismatch;
    logic [64:0] dl_sum;
    logic [63:0] dl_sat;
    logic [3:0]  idx_base;
    logic [47:0] triple;
    logic        dup;
    logic [7:0]  rec_mid;

    always_comb begin
        held     = i_in.now_us < i_state.deadline;
        checking = !held && (i_state.recovery_left == '0);
        mismatch = i_in.check_readback !=
                   expected_byte(i_cfg.exp_lo, i_cfg.exp_hi, i_state.check_idx);
        dl_sum   = {1'b0, i_in.now_us} + {45'd0, i_cfg.holdoff_us};
        dl_sat   = dl_sum[64] ? '1 : dl_sum[63:0];
        idx_base = mismatch ? 4'd0 : i_state.check_idx;
        triple   = {i_in.accel_x, i_in.accel_y, i_in.accel_z};
        dup      = checking && !i_state.dup_seen && (triple == i_state.last_triple);
        rec_mid  = (checking && mismatch) ? i_cfg.recovery_ticks : i_state.recovery_left;

        o_state = i_state;
        o_word  = '0;

        if (checking) begin
            if (mismatch) begin
                if (i_state.err_cnt != '1) begin
                    o_state.err_cnt = i_state.err_cnt + 32'd1;
                end
                o_state.deadline = dl_sat;
            end
            o_state.check_idx = (idx_base == IDX_LAST) ? 4'd0 : idx_base + 4'd1;
            if (dup) begin
                o_state.dup_seen = 1'b1;
            end else begin
                o_state.last_triple = triple;
                o_state.dup_seen    = 1'b0;
            end
            o_state.recovery_left = rec_mid;
        end

        if (held) begin
            o_word.status = ST_HELD;
        end else if (dup) begin
            o_word.status = ST_DUP;
        end else if (rec_mid != '0) begin
            o_state.recovery_left = rec_mid - 8'd1;
            o_word.status         = ST_RECOV;
        end else begin
            o_word.status          = ST_VALID;
            o_word.out_accel_x     = i_in.accel_y;
            o_word.out_accel_y     = sat_negate(i_in.accel_x);
            o_word.out_accel_z     = i_in.accel_z;
            o_word.out_gyro_x      = i_in.gyro_y;
            o_word.out_gyro_y      = sat_negate(i_in.gyro_x);
            o_word.out_gyro_z      = i_in.gyro_z;
            o_word.out_temperature = i_in.temperature_raw;
        end

        o_word.reset_request    = checking && mismatch;
        o_word.next_check_index = o_state.check_idx;
        o_word.mismatch_total   = o_state.err_cnt;
    end

endmodule

>>> src/imu_shq_sample_health_qualifier_top.sv
// Top level of the IMU sample health qualifier: input register, poll evaluation,
// result register, configuration registers. Depends on imu_shq_pkg, imu_shq_ifs,
// imu_shq_step.
//
//   channel    dir  handshake        word
//   i_sample   in   valid/ready      t_in_word  (one sensor poll)
//   o_result   out  valid/ready      t_out_word (one result per poll)
//   i_cfg_*    in   write enable     register index + 64-bit data
//
// One word per cycle sustained while o_result.ready holds.
// The poll is evaluated between the input register and the result register, and the
// state registers update in the same cycle the word moves on.
// Reset is synchronous; it clears state, valid flags and loads register defaults.
// A stalled result holds the input register; ready drops only when both are full.

module imu_sample_health_qualifier_top import imu_shq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    imu_shq_in_if.sink            i_sample,
    imu_shq_out_if.source         o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_in_vld;
    t_in_word  r_in;
    logic      r_out_vld;
    t_out_word r_out;
    t_state    r_state;
    t_state    n_state;
    t_cfg      r_cfg;
    t_out_word n_out;
    logic      advance;

    assign advance        = r_in_vld && (!r_out_vld || o_result.ready);
    assign i_sample.ready = !r_in_vld || advance;
    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

    imu_shq_step u_step (
        .i_in    (r_in),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_word  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (i_sample.ready) begin
                r_in_vld <= i_sample.valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.ready && i_sample.valid) begin
            r_in <= i_sample.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exp_lo         <= '0;
            r_cfg.exp_hi         <= '0;
            r_cfg.holdoff_us     <= HOLDOFF_RST;
            r_cfg.recovery_ticks <= RECOVERY_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_EXP_LO:   r_cfg.exp_lo         <= i_cfg_data;
                CFG_EXP_HI:   r_cfg.exp_hi         <= i_cfg_data[23:0];
                CFG_HOLDOFF:  r_cfg.holdoff_us     <= i_cfg_data[19:0];
                CFG_RECOVERY: r_cfg.recovery_ticks <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.check_idx <= IDX_LAST)
        else $error("check index out of range");

    a_held_no_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status == ST_HELD) |-> !r_out.reset_request)
        else $error("reset request on a held poll");

    a_blank_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status != ST_VALID) |->
            (r_out.out_accel_x == '0 && r_out.out_accel_y == '0 &&
             r_out.out_gyro_x == '0 && r_out.out_gyro_y == '0 &&
             r_out.out_temperature == '0))
        else $error("sample fields set on a non-valid result");

    a_err_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_state.err_cnt >= $past(r_state.err_cnt))
        else $error("error count decreased");

endmodule

>>> tb/tb_imu_sample_health_qualifier_top.sv
// Self-checking testbench for imu_sample_health_qualifier_top: directed and random polls,
// randomized valid/ready idling, a scoreboard class that predicts each result word.
// Depends on imu_shq_pkg, imu_shq_ifs and the RTL top.

module tb_imu_sample_health_qualifier_top;
    import imu_shq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    class qualifier_scoreboard;
        logic [63:0] exp_lo;
        logic [23:0] exp_hi;
        logic [19:0] holdoff_us;
        logic [7:0]  recovery_ticks;

        logic [63:0] deadline;
        logic [7:0]  recov_left;
        logic [3:0]  check_idx;
        logic [47:0] last_triple;
        logic        dup_seen;
        logic [31:0] err_cnt;

        t_out_word   result_q[$];
        int          failures;

        function new();
            exp_lo         = '0;
            exp_hi         = '0;
            holdoff_us     = HOLDOFF_RST;
            recovery_ticks = RECOVERY_RST;
            deadline       = '0;
            recov_left     = '0;
            check_idx      = '0;
            last_triple    = '0;
            dup_seen       = 1'b0;
            err_cnt        = '0;
            failures       = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [63:0] v);
            case (idx)
                CFG_EXP_LO:   exp_lo = v;
                CFG_EXP_HI:   exp_hi = v[23:0];
                CFG_HOLDOFF:  holdoff_us = v[19:0];
                CFG_RECOVERY: recovery_ticks = v[7:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] expected_readback();
            logic [87:0] all_bytes;
            all_bytes = {exp_hi, exp_lo};
            return all_bytes[check_idx * 8 +: 8];
        endfunction

        function logic signed [15:0] neg_sat(logic signed [15:0] v);
            return (v == SAMPLE_MIN) ? SAMPLE_MAX : -v;
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        function void note_poll(t_in_word w);
            t_out_word   e;
            logic [47:0] triple;
            logic        dropped;
            e = '0;
            if (w.now_us < deadline) begin
                e.status = ST_HELD;
            end else begin
                dropped = 1'b0;
                if (recov_left == 0) begin
                    if (w.check_readback != expected_readback()) begin
                        if (err_cnt != '1) err_cnt++;
                        e.reset_request = 1'b1;
                        if (w.now_us > TIME_MAX - 64'(holdoff_us)) deadline = TIME_MAX;
                        else deadline = w.now_us + 64'(holdoff_us);
                        check_idx  = '0;
                        recov_left = recovery_ticks;
                    end
                    check_idx = (check_idx == IDX_LAST) ? 4'd0 : check_idx + 4'd1;
                    triple = {w.accel_x, w.accel_y, w.accel_z};
                    if (!dup_seen && triple == last_triple) begin
                        dup_seen = 1'b1;
                        dropped  = 1'b1;
                    end else begin
                        last_triple = triple;
                        dup_seen    = 1'b0;
                    end
                end
                if (dropped) begin
                    e.status = ST_DUP;
                end else if (recov_left != 0) begin
                    recov_left--;
                    e.status = ST_RECOV;
                end else begin
                    e.status          = ST_VALID;
                    e.out_accel_x     = w.accel_y;
                    e.out_accel_y     = neg_sat(w.accel_x);
                    e.out_accel_z     = w.accel_z;
                    e.out_gyro_x      = w.gyro_y;
                    e.out_gyro_y      = neg_sat(w.gyro_x);
                    e.out_gyro_z      = w.gyro_z;
                    e.out_temperature = w.temperature_raw;
                end
            end
            e.next_check_index = check_idx;
            e.mismatch_total   = err_cnt;
            result_q.push_back(e);
        endfunction

        function void cmp(string name, logic signed [63:0] want, logic signed [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (result_q.size() == 0) begin
                $error("result word with no poll outstanding");
                failures++;
                return;
            end
            want = result_q.pop_front();
            cmp("status", want.status, got.status);
            cmp("out_accel_x", want.out_accel_x, got.out_accel_x);
            cmp("out_accel_y", want.out_accel_y, got.out_accel_y);
            cmp("out_accel_z", want.out_accel_z, got.out_accel_z);
            cmp("out_gyro_x", want.out_gyro_x, got.out_gyro_x);
            cmp("out_gyro_y", want.out_gyro_y, got.out_gyro_y);
            cmp("out_gyro_z", want.out_gyro_z, got.out_gyro_z);
            cmp("out_temperature", want.out_temperature, got.out_temperature);
            cmp("reset_request", want.reset_request, got.reset_request);
            cmp("next_check_index", want.next_check_index, got.next_check_index);
            cmp("mismatch_total", want.mismatch_total, got.mismatch_total);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    imu_shq_in_if  in_if ();
    imu_shq_out_if out_if ();

    imu_sample_health_qualifier_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (in_if),
        .o_result   (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    qualifier_scoreboard sb = new();

    logic [63:0] clock_us;
    logic [47:0] prev_triple;
    int          tx_calm;
    int          rx_calm;
    int          rx_stall;
    int          idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 19))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_word random_poll(int bad_pct);
        t_in_word    w;
        int          r;
        logic [47:0] triple;
        r = $urandom_range(0, 99);
        if (r < 88) clock_us += $urandom_range(0, 3000);
        else if (r < 97) clock_us += $urandom_range(3000, 2_000_000);
        w.now_us = clock_us;
        if ($urandom_range(0, 3) == 0) triple = prev_triple;
        else triple = {pick_sample(), pick_sample(), pick_sample()};
        prev_triple = triple;
        {w.accel_x, w.accel_y, w.accel_z} = triple;
        w.gyro_x          = pick_sample();
        w.gyro_y          = pick_sample();
        w.gyro_z          = pick_sample();
        w.temperature_raw = pick_sample();
        w.check_readback  = sb.expected_readback();
        // stray timestamps keep a matching readback so the deadline stays put
        if ($urandom_range(0, 49) == 0) w.now_us = {$urandom, $urandom};
        else if ($urandom_range(1, 100) <= bad_pct) w.check_readback = 8'($urandom);
        return w;
    endfunction

    task automatic send_poll(t_in_word w);
        int gap;
        gap = pick_gap(tx_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_poll(w);
    endtask

    task automatic poll_at(logic [63:0] now, bit bad);
        t_in_word w;
        w = random_poll(0);
        w.now_us = now;
        if (bad) w.check_readback = ~sb.expected_readback();
        send_poll(w);
    endtask

    task automatic poll_fields(logic [63:0] now, logic [15:0] ax, logic [15:0] ay,
                               logic [15:0] az, logic [15:0] gx, logic [15:0] gy,
                               logic [15:0] gz, logic [15:0] tmp);
        t_in_word w;
        w.now_us          = now;
        w.accel_x         = ax;
        w.accel_y         = ay;
        w.accel_z         = az;
        w.gyro_x          = gx;
        w.gyro_y          = gy;
        w.gyro_z          = gz;
        w.temperature_raw = tmp;
        w.check_readback  = sb.expected_readback();
        prev_triple = {ax, ay, az};
        send_poll(w);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(logic [63:0] lo, logic [23:0] hi, logic [19:0] hold,
                                logic [7:0] rec);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_EXP_LO;
        i_cfg_data <= lo;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_EXP_HI;
        i_cfg_data <= 64'(hi);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_HOLDOFF;
        i_cfg_data <= 64'(hold);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_RECOVERY;
        i_cfg_data <= 64'(rec);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(CFG_EXP_LO, lo);
        sb.set_reg(CFG_EXP_HI, 64'(hi));
        sb.set_reg(CFG_HOLDOFF, 64'(hold));
        sb.set_reg(CFG_RECOVERY, 64'(rec));
    endtask

    // result side: random stalls, checks at the rising edge
    initial begin
        out_if.ready = 1'b0;
        rx_calm  = 0;
        rx_stall = 0;
        forever begin
            @(negedge i_clk);
            if (rx_stall > 0) begin
                out_if.ready <= 1'b0;
                rx_stall--;
            end else begin
                out_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) rx_stall = pick_gap(rx_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            sb.check_result(out_if.data);
    end

    initial idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [63:0] lo;
        logic [23:0] hi;
        logic [19:0] hold;
        logic [7:0]  rec;
        int          r;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_EXP_LO;
        i_cfg_data  = '0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        tx_calm     = 0;
        prev_triple = '0;
        clock_us    = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: zero triple repeats the cleared history, then extremes
        poll_fields(64'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        poll_fields(64'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        poll_fields(64'd1, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
        poll_fields(64'd2, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        poll_fields(64'd3, 16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF);
        poll_at(TIME_MAX, 1'b0);
        // mismatch under default hold-off and recovery, then held, then recovering
        poll_at(64'd100, 1'b1);
        poll_at(64'd10099, 1'b0);
        poll_at(64'd10100, 1'b1);
        clock_us = 64'd20000;
        repeat (20) send_poll(random_poll(0));

        // zero hold-off and recovery: mismatch still emits; mismatch with duplicate
        program_regs(64'h8877_6655_4433_2211, 24'hCCBBAA, 20'd0, 8'd0);
        clock_us += 10;
        poll_at(clock_us, 1'b1);
        prev_triple = {in_if.data.accel_x, in_if.data.accel_y, in_if.data.accel_z};
        begin
            t_in_word w;
            w = in_if.data;
            w.check_readback = ~sb.expected_readback();
            send_poll(w);
        end
        repeat (11) send_poll(random_poll(0));

        // hold-off of 1000000 and largest recovery
        program_regs({$urandom, $urandom}, 24'($urandom), 20'd1000000, 8'd255);
        clock_us += 10;
        poll_at(clock_us, 1'b1);
        poll_at(clock_us + 64'd999999, 1'b0);
        clock_us += 64'd1000000;
        poll_at(clock_us, 1'b0);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    lo = '1;
                    hi = '1;
                end
                1: begin
                    lo = '0;
                    hi = '0;
                end
                default: begin
                    lo = {$urandom, $urandom};
                    hi = 24'($urandom);
                end
            endcase
            r = $urandom_range(0, 99);
            if (r < 20) hold = 20'd0;
            else if (r < 35) hold = 20'd1000000;
            else hold = 20'($urandom_range(1, 5000));
            r = $urandom_range(0, 99);
            if (r < 25) rec = 8'd0;
            else if (r < 32) rec = 8'd255;
            else rec = 8'($urandom_range(1, 8));
            program_regs(lo, hi, hold, rec);
            repeat (67) begin
                send_poll(random_poll(15));
                if ($urandom_range(0, 59) == 0) drain();
            end
        end

        // deadline saturation near the top of the time range
        program_regs({$urandom, $urandom}, 24'($urandom), 20'd1000000, 8'd0);
        poll_at(TIME_MAX - 64'd5, 1'b1);
        poll_at(TIME_MAX - 64'd1, 1'b0);
        poll_at(TIME_MAX, 1'b1);
        poll_at(TIME_MAX, 1'b0);

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
